FILE: rtl/aht_pkg.sv
// Shared types, constants and helpers for the address hit tally table.
`timescale 1ns / 1ps

package aht_pkg;

  localparam int KEY_W  = 64;
  localparam int CNT_W  = 32;
  localparam int SLOT_W = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // action codes carried on s_axis_tuser
  localparam logic ACT_TALLY = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // one result item; first member is the most significant
  typedef struct packed {
    logic [CNT_W-1:0] overflow_total;
    logic [CNT_W-1:0] slot_count;
    logic [KEY_W-1:0] slot_key;
    logic [KEY_W-1:0] new_key;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

FILE: rtl/address_hit_tally_table.sv
// Top level of the address hit tally table: control, key/count stores, output.
`timescale 1ns / 1ps
// Usage:
//   cfg_*    : writes base_address (64 bit); always ready. Write only while idle.
//   s_axis_* : one item per transaction. tuser = action (0 tally, 1 read);
//              tdata = return_address [63:0], slot [68:64].
//   m_axis_* : one result per item, tdata = new_key, slot_key, slot_count,
//              overflow_total from the lowest bit up.
// Timing:
//   A tally walks the table one slot per cycle through the key and count
//   RAM read ports (registered read data) and ends at the first matching
//   or empty slot, or after all ENTRIES slots on a miss. A read goes from
//   its read state, and a tally from its scan, to the hold state, which hands
//   the result to the output register; the next item is taken once it has.
//   One item is in work at a time; s_axis_tready is high only when idle.
// Reset:
//   Synchronous rst clears the per-slot valid flags (unwritten slots read
//   as key 0, count 0), the overflow count and base_address at once.
// Stall:
//   A result waits in the output register; while it and the next finished
//   result are both held, the block waits and takes no new item.
module address_hit_tally_table
  import aht_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic                clk,
  input  logic                rst,
  // configuration: base_address
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [KEY_W-1:0]    cfg_data,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [71:0]         s_axis_tdata,   // return_address[63:0], slot[68:64], zero pad
  input  logic                s_axis_tuser,   // action
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [RESULT_W-1:0] m_axis_tdata    // new_key, slot_key, slot_count, overflow_total
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SWW = AW + SLOT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]         state;
  logic [KEY_W-1:0]   base_address;
  logic [KEY_W-1:0]   rel;
  logic [AW-1:0]      idx;
  logic               slot_ok;
  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   miss;
  result_t            res;

  logic [KEY_W-1:0]   in_addr;
  logic [SLOT_W-1:0]  in_slot;
  logic [SWW-1:0]     slot_wide;
  logic               in_accept;
  logic [KEY_W-1:0]   rel_next;

  logic [AW-1:0]      raddr;
  logic [KEY_W-1:0]   key_rdata;
  logic [CNT_W-1:0]   cnt_rdata;
  logic               mem_we;
  logic [CNT_W-1:0]   cnt_wdata;

  logic [KEY_W-1:0]   cur_key;
  logic [CNT_W-1:0]   cur_cnt;
  logic               hit;
  logic               last;

  logic               out_load_ready;
  result_t            out_data;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_addr       = s_axis_tdata[63:0];
  assign in_slot       = s_axis_tdata[68:64];
  assign slot_wide     = SWW'(in_slot);

  assign rel_next = (base_address != '0 && in_addr >= base_address)
                    ? in_addr - base_address : in_addr;

  // unwritten slots read as empty
  assign cur_key = valid[idx] ? key_rdata : '0;
  assign cur_cnt = valid[idx] ? cnt_rdata : '0;
  assign hit     = (cur_key == rel) || (cur_key == '0);
  assign last    = (idx == AW'(ENTRIES - 1));
  assign mem_we  = (state == ST_SCAN) && hit;
  // on a match the key is already rel, so the key is always rewritten as rel
  assign cnt_wdata = sat_inc(cur_cnt);

  always_comb begin
    raddr = '0;
    if (state == ST_IDLE) begin
      raddr = (s_axis_tuser == ACT_READ) ? slot_wide[AW-1:0] : '0;
    end else if (state == ST_SCAN) begin
      raddr = idx + AW'(1);
    end
  end

  aht_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx),
    .wdata (rel),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  aht_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx),
    .wdata (cnt_wdata),
    .raddr (raddr),
    .rdata (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      base_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
      miss  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= (s_axis_tuser == ACT_READ) ? ST_READ : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            valid[idx] <= 1'b1;
            state      <= ST_HOLD;
          end else if (last) begin
            miss  <= sat_inc(miss);
            state <= ST_HOLD;
          end
        end
        ST_READ: begin
          state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_load_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          rel     <= rel_next;
          idx     <= (s_axis_tuser == ACT_READ) ? slot_wide[AW-1:0] : '0;
          slot_ok <= (slot_wide < SWW'(ENTRIES));
        end
      end
      ST_SCAN: begin
        res.slot_key   <= '0;
        res.slot_count <= '0;
        if (hit) begin
          res.new_key        <= (cur_key == '0) ? rel : '0;
          res.overflow_total <= miss;
        end else if (last) begin
          res.new_key        <= '0;
          res.overflow_total <= sat_inc(miss);
        end else begin
          idx <= idx + AW'(1);
        end
      end
      ST_READ: begin
        res.new_key        <= '0;
        res.slot_key       <= slot_ok ? cur_key : '0;
        res.slot_count     <= slot_ok ? cur_cnt : '0;
        res.overflow_total <= miss;
      end
      default: begin
      end
    endcase
  end

  aht_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (state == ST_HOLD),
    .load_ready (out_load_ready),
    .load_data  (res),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .m_data     (out_data)
  );

  assign m_axis_tdata = out_data;

`ifndef SYNTHESIS
  a_tally_starts_scan: assert property (@(posedge clk) disable iff (rst)
    in_accept && (s_axis_tuser == ACT_TALLY) |=> (state == ST_SCAN) && (idx == '0))
    else $error("tally did not start its scan at slot zero");

  a_write_ends_scan: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (state == ST_HOLD))
    else $error("table write did not end the scan");

  a_result_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_HOLD))
    else $error("result appeared without a held result");

  a_miss_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (miss != $past(miss)) |-> (&$past(valid)))
    else $error("overflow counted while a slot was still free");
`endif

endmodule

FILE: rtl/aht_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module aht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/aht_out_reg.sv
// Output register holding one result transaction until the receiver takes it.
`timescale 1ns / 1ps

module aht_out_reg
  import aht_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load_valid,
  output logic    load_ready,
  input  result_t load_data,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_data
);

  assign load_ready = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load_ready) begin
      m_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      m_data <= load_data;
    end
  end

endmodule

FILE: tb/address_hit_tally_table_test.sv
// Self-checking testbench for the address hit tally table: directed and random tallies and reads.
`timescale 1ns / 1ps

module address_hit_tally_table_test;
  import aht_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [KEY_W-1:0]    cfg_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [71:0]         s_axis_tdata = '0;   // return_address[63:0], slot[68:64], zero pad
  logic                s_axis_tuser = 1'b0; // action
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [RESULT_W-1:0] m_axis_tdata;        // new_key, slot_key, slot_count, overflow_total

  // shadow of the block state
  logic [KEY_W-1:0] table_keys   [TABLE_DEPTH];
  logic [CNT_W-1:0] table_counts [TABLE_DEPTH];
  logic [CNT_W-1:0] miss_total;
  logic [KEY_W-1:0] base_reg;

  result_t pending_results [$];
  int      error_count = 0;
  int      quiet_cycles = 0;
  int      send_idle = 30;
  int      recv_idle = 73;

  address_hit_tally_table #(
    .ENTRIES(TABLE_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [CNT_W-1:0] saturating_bump(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  // Updates the shadow state for one item and returns its result.
  function automatic result_t predict_result(input logic action, input logic [KEY_W-1:0] addr,
                                             input logic [SLOT_W-1:0] slot);
    result_t          r;
    logic [KEY_W-1:0] rel;
    bit               done;
    r = '0;
    if (action == ACT_TALLY) begin
      rel = (base_reg != '0 && addr >= base_reg) ? addr - base_reg : addr;
      done = 1'b0;
      for (int i = 0; i < TABLE_DEPTH && !done; i++) begin
        // match is checked first, so a zero address counts in the first empty slot
        if (table_keys[i] == rel) begin
          table_counts[i] = saturating_bump(table_counts[i]);
          done = 1'b1;
        end else if (table_keys[i] == '0) begin
          table_keys[i] = rel;
          table_counts[i] = saturating_bump(table_counts[i]);
          r.new_key = rel;
          done = 1'b1;
        end
      end
      if (!done) miss_total = saturating_bump(miss_total);
    end else if (slot < TABLE_DEPTH) begin
      r.slot_key = table_keys[slot];
      r.slot_count = table_counts[slot];
    end
    r.overflow_total = miss_total;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic action, input logic [KEY_W-1:0] addr,
                           input logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= action;
    s_axis_tdata <= {3'b000, slot, addr};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_result(action, addr, slot));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk);
  endtask

  task automatic write_base(input logic [KEY_W-1:0] value);
    wait_drained();
    repeat (TABLE_DEPTH + 4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    base_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_reads();
    send_item(ACT_READ, '0, 5'd0);
    send_item(ACT_READ, '1, 5'd31);
  endtask

  // zero address counts in slot 0 without claiming it
  task automatic test_zero_address();
    send_item(ACT_TALLY, '0, 5'd0);
    send_item(ACT_TALLY, '0, 5'd31);
    send_item(ACT_READ, '0, 5'd0);
  endtask

  // claim keeps the count gathered by zero tallies, then a plain hit
  task automatic test_claim_and_hit();
    send_item(ACT_TALLY, '1, 5'd0);
    send_item(ACT_TALLY, '1, 5'd0);
    send_item(ACT_READ, '0, 5'd0);
  endtask

  task automatic test_base_subtract();
    write_base(64'h1000);
    send_item(ACT_TALLY, 64'h1000, 5'd0);  // relative zero
    send_item(ACT_TALLY, 64'h0fff, 5'd0);  // below base, kept
    send_item(ACT_TALLY, 64'h1005, 5'd0);  // relative 5
    send_item(ACT_TALLY, 64'h0005, 5'd0);  // below base, hits key 5
    send_item(ACT_READ, '0, 5'd1);
    send_item(ACT_READ, '0, 5'd2);
  endtask

  task automatic test_base_extreme();
    write_base('1);
    send_item(ACT_TALLY, '1, 5'd0);
    send_item(ACT_TALLY, 64'hffff_ffff_ffff_fffe, 5'd0);
    send_item(ACT_TALLY, '0, 5'd0);
    send_item(ACT_READ, '0, 5'd3);
  endtask

  task automatic send_random_item();
    int               pick;
    int               j;
    logic [KEY_W-1:0] addr;
    logic [KEY_W-1:0] k;
    logic [KEY_W:0]   sum;
    pick = $urandom_range(99);
    addr = {$urandom, $urandom};
    if (pick < 20) begin
      send_item(ACT_READ, addr, SLOT_W'($urandom_range(31)));
      return;
    end
    if (pick < 60) begin
      // aim at a key already in the table
      j = $urandom_range(TABLE_DEPTH - 1);
      k = table_keys[j];
      if (k != '0) begin
        sum = {1'b0, k} + {1'b0, base_reg};
        if (base_reg == '0 || k < base_reg) addr = k;
        else if (!sum[KEY_W]) addr = sum[KEY_W-1:0];
        else addr = k;
      end
    end else if (pick < 70) begin
      addr = base_reg;
    end else if (pick < 80) begin
      addr = base_reg + KEY_W'($urandom_range(255));
    end
    send_item(ACT_TALLY, addr, SLOT_W'($urandom_range(31)));
  endtask

  task automatic test_random_traffic(input int count, input int s_idle, input int r_idle,
                                     input logic [KEY_W-1:0] base);
    write_base(base);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_drained();
      send_random_item();
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: %h", m_axis_tdata);
        error_count = error_count + 1;
      end else begin
        want = pending_results.pop_front();
        if (got.new_key !== want.new_key) begin
          $error("new_key: expected %h, actual %h", want.new_key, got.new_key);
          error_count = error_count + 1;
        end
        if (got.slot_key !== want.slot_key) begin
          $error("slot_key: expected %h, actual %h", want.slot_key, got.slot_key);
          error_count = error_count + 1;
        end
        if (got.slot_count !== want.slot_count) begin
          $error("slot_count: expected %h, actual %h", want.slot_count, got.slot_count);
          error_count = error_count + 1;
        end
        if (got.overflow_total !== want.overflow_total) begin
          $error("overflow_total: expected %h, actual %h", want.overflow_total,
                 got.overflow_total);
          error_count = error_count + 1;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      table_keys[i] = '0;
      table_counts[i] = '0;
    end
    miss_total = '0;
    base_reg = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_reads();
    test_zero_address();
    test_claim_and_hit();
    test_base_subtract();
    test_base_extreme();
    test_random_traffic(250, 30, 73, {$urandom, $urandom});
    test_random_traffic(250, 73, 30, '0);
    test_random_traffic(250, 0, 0, '1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
